/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the serializer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only out of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked only out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hw/rtl/cms_pkg.sv */
package cms_pkg;

    typedef enum logic [2:0] {
        OP_HEADER    = 3'd0,
        OP_TOKEN     = 3'd1,
        OP_OPT_HDR   = 3'd2,
        OP_OPT_BYTE  = 3'd3,
        OP_PAY_START = 3'd4,
        OP_PAY_BYTE  = 3'd5
    } opcode_t;

    localparam int MAX_BEATS   = 5;
    localparam int BEAT_W      = 3;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [15:0] OPT_EXT1     = 16'd13;
    localparam logic [15:0] OPT_EXT2     = 16'd269;
    localparam logic [3:0]  NIB_EXT1     = 4'd13;
    localparam logic [3:0]  NIB_EXT2     = 4'd14;
    localparam logic [7:0]  PAYLOAD_MARK = 8'hFF;
    localparam logic [15:0] HDR_BYTES    = 16'd4;
    localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

    // One classified item: the bytes it emits and how to report them.
    typedef struct packed {
        logic [MAX_BEATS-1:0][7:0] bytes;
        logic [BEAT_W-1:0]         nbeats;   // 1..MAX_BEATS
        logic                      emit;     // beats carry real bytes
        logic                      dropped;
        logic [15:0]               base;     // written count before this item
    } cms_entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

/* hw/rtl/coap_message_serializer_core.sv */
// CoAP message serializer core.
// Input channel (item_valid / item_stall): one item per beat, tagged by opcode:
// header, token byte, option header, option byte, payload start, payload byte.
// Result channel (result_valid / result_stall): one serialized byte per beat,
// with out_valid, item_dropped, last_of_run and the running total_written.
// Each item gives one to five result beats; an option header with extended
// delta and length forms gives the most; a kept header gives four, others one.
// An accepted item is first written into the item queue; each of its beats is
// then loaded from the queue head into the output register and presented there.
// Throughput: one result beat per cycle while result_stall is low, set by the
// single output register; items flow at one per cycle while each yields one
// beat, and the item queue absorbs bursts of multi-byte option headers.
// When the receiver stalls, the output beat holds and the queue fills; once
// it is full, item_stall rises until the back end drains an entry.
// Reset clears the buffer room, the byte count, the token and payload
// enables, empties the queue and drops any pending result beat.
module coap_message_serializer_core #(
    parameter int QueueDepth = cms_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [2:0]  opcode,
    input  logic [1:0]  version,
    input  logic [1:0]  msg_type,
    input  logic [3:0]  token_length,
    input  logic [7:0]  code,
    input  logic [15:0] message_id,
    input  logic [15:0] capacity,
    input  logic [7:0]  data_byte,
    input  logic [15:0] option_number,
    input  logic [15:0] option_length,
    input  logic [15:0] payload_length,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [7:0]  out_byte,
    output logic        out_valid,
    output logic        last_of_run,
    output logic        item_dropped,
    output logic [15:0] total_written
);
    import cms_pkg::*;

    cms_entry_t front_entry;
    cms_entry_t head;
    q_status_t  q_status;
    logic       accept;
    logic       pop;

    // Take an item whenever the queue has a free slot.
    assign item_stall = q_status.full;
    assign accept     = item_valid && !item_stall;

    // Front: classify the item, pack its bytes, advance message state.
    cms_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .opcode         (opcode),
        .version        (version),
        .msg_type       (msg_type),
        .token_length   (token_length),
        .code           (code),
        .message_id     (message_id),
        .capacity       (capacity),
        .data_byte      (data_byte),
        .option_number  (option_number),
        .option_length  (option_length),
        .payload_length (payload_length),
        .entry          (front_entry)
    );

    // Queue: decouple item acceptance from byte emission.
    cms_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_entry (front_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    // Back: emit one byte beat per cycle unless the result side stalls, drop the entry after its last beat.
    cms_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .q_status      (q_status),
        .pop           (pop),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .out_byte      (out_byte),
        .out_valid     (out_valid),
        .last_of_run   (last_of_run),
        .item_dropped  (item_dropped),
        .total_written (total_written)
    );

endmodule

/* hw/rtl/cms_front.sv */
module cms_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [2:0]         opcode,
    input  logic [1:0]         version,
    input  logic [1:0]         msg_type,
    input  logic [3:0]         token_length,
    input  logic [7:0]         code,
    input  logic [15:0]        message_id,
    input  logic [15:0]        capacity,
    input  logic [7:0]         data_byte,
    input  logic [15:0]        option_number,
    input  logic [15:0]        option_length,
    input  logic [15:0]        payload_length,
    output cms_pkg::cms_entry_t entry
);
    import cms_pkg::*;

    logic [15:0] room_reg, room_next;
    logic [15:0] written_reg, written_next;
    logic        token_en_reg, token_en_next;
    logic        pay_en_reg, pay_en_next;

    logic [3:0]  nib_on, nib_ol;
    logic [1:0]  ext_on, ext_ol;
    logic [15:0] on_e2, ol_e2;
    logic [7:0]  on_e1, ol_e1;
    logic [2:0]  pos;
    logic [15:0] n_emit;
    logic [15:0] hdr_room;
    logic [16:0] written_sum;

    function automatic logic [3:0] nibble_of(input logic [15:0] v);
        logic [3:0] r;
        if (v >= OPT_EXT2)
            r = NIB_EXT2;
        else if (v >= OPT_EXT1)
            r = NIB_EXT1;
        else
            r = v[3:0];
        return r;
    endfunction

    function automatic logic [1:0] ext_len(input logic [15:0] v);
        logic [1:0] r;
        if (v >= OPT_EXT2)
            r = 2'd2;
        else if (v >= OPT_EXT1)
            r = 2'd1;
        else
            r = 2'd0;
        return r;
    endfunction

    always_comb
    begin
        nib_on = nibble_of(option_number);
        nib_ol = nibble_of(option_length);
        ext_on = ext_len(option_number);
        ext_ol = ext_len(option_length);
        on_e2  = option_number - OPT_EXT2;
        ol_e2  = option_length - OPT_EXT2;
        on_e1  = 8'(option_number - OPT_EXT1);
        ol_e1  = 8'(option_length - OPT_EXT1);
        pos    = 3'd1 + {1'b0, ext_on};
        hdr_room = (capacity >= HDR_BYTES) ? capacity - HDR_BYTES : capacity;
    end

    // Classify the item and build its queue entry.
    always_comb
    begin
        entry         = '0;
        entry.nbeats  = 3'd1;
        entry.base    = written_reg;
        token_en_next = token_en_reg;
        pay_en_next   = pay_en_reg;
        case (opcode_t'(opcode))
            OP_HEADER:
            begin
                entry.base    = '0;
                pay_en_next   = 1'b0;
                token_en_next = (hdr_room >= {12'd0, token_length});
                if (capacity < HDR_BYTES)
                begin
                    entry.dropped = 1'b1;
                end
                else
                begin
                    entry.emit     = 1'b1;
                    entry.nbeats   = 3'd4;
                    entry.bytes[0] = {version, msg_type, token_length};
                    entry.bytes[1] = code;
                    entry.bytes[2] = message_id[15:8];
                    entry.bytes[3] = message_id[7:0];
                end
            end
            OP_TOKEN:
            begin
                if (token_en_reg)
                begin
                    entry.emit     = 1'b1;
                    entry.bytes[0] = data_byte;
                end
                else
                begin
                    entry.dropped = 1'b1;
                end
            end
            OP_OPT_HDR:
            begin
                entry.emit     = 1'b1;
                entry.nbeats   = 3'd1 + {1'b0, ext_on} + {1'b0, ext_ol};
                entry.bytes[0] = {nib_on, nib_ol};
                if (ext_on == 2'd2)
                begin
                    entry.bytes[1] = on_e2[15:8];
                    entry.bytes[2] = on_e2[7:0];
                end
                else if (ext_on == 2'd1)
                begin
                    entry.bytes[1] = on_e1;
                end
                if (ext_ol == 2'd2)
                begin
                    entry.bytes[pos]        = ol_e2[15:8];
                    entry.bytes[pos + 3'd1] = ol_e2[7:0];
                end
                else if (ext_ol == 2'd1)
                begin
                    entry.bytes[pos] = ol_e1;
                end
            end
            OP_OPT_BYTE:
            begin
                entry.emit     = 1'b1;
                entry.bytes[0] = data_byte;
            end
            OP_PAY_START:
            begin
                pay_en_next = 1'b0;
                if ({1'b0, payload_length} + 17'd1 > {1'b0, room_reg})
                begin
                    entry.dropped = 1'b1;
                end
                else if (payload_length != 16'd0)
                begin
                    pay_en_next    = 1'b1;
                    entry.emit     = 1'b1;
                    entry.bytes[0] = PAYLOAD_MARK;
                end
            end
            OP_PAY_BYTE:
            begin
                if (pay_en_reg)
                begin
                    entry.emit     = 1'b1;
                    entry.bytes[0] = data_byte;
                end
                else
                begin
                    entry.dropped = 1'b1;
                end
            end
            default:
            begin
                entry.emit = 1'b0;
            end
        endcase
    end

    // Room and count advance by the bytes this item emits, saturating; a header reloads the room from the capacity.
    always_comb
    begin
        n_emit      = entry.emit ? {13'd0, entry.nbeats} : 16'd0;
        written_sum = {1'b0, entry.base} + {1'b0, n_emit};
        written_next = written_sum[16] ? COUNT_MAX : written_sum[15:0];
        if (opcode_t'(opcode) == OP_HEADER)
            room_next = hdr_room;
        else if (room_reg >= n_emit)
            room_next = room_reg - n_emit;
        else
            room_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            room_reg     <= '0;
            written_reg  <= '0;
            token_en_reg <= 1'b0;
            pay_en_reg   <= 1'b0;
        end
        else if (accept)
        begin
            room_reg     <= room_next;
            written_reg  <= written_next;
            token_en_reg <= token_en_next;
            pay_en_reg   <= pay_en_next;
        end
    end

endmodule

/* hw/rtl/cms_queue.sv */
module cms_queue #(
    parameter int Depth = cms_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cms_pkg::cms_entry_t push_entry,
    input  logic                pop,
    output cms_pkg::cms_entry_t head,
    output cms_pkg::q_status_t  status
);
    import cms_pkg::*;
    `include "assert_macros.svh"

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    cms_entry_t          slots_reg [Depth];
    logic [PtrW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]     cnt_reg, cnt_next;

    assign head         = slots_reg[rd_ptr_reg];
    assign status.empty = (cnt_reg == '0);
    assign status.full  = (cnt_reg == FullCnt);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_entry;
    end

    `ASSERT_IMPLIES(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= FullCnt)
    `ASSERT_IMPLIES(a_no_pop_empty, clk, rst_n, pop, cnt_reg != '0)
    `ASSERT_IMPLIES(a_no_push_full, clk, rst_n, push, cnt_reg != FullCnt)
    `ASSERT_NEXT(a_push_grows, clk, rst_n, push && !pop, cnt_reg == $past(cnt_reg) + 1'b1)

endmodule

/* hw/rtl/cms_back.sv */
module cms_back (
    input  logic                clk,
    input  logic                rst_n,
    input  cms_pkg::cms_entry_t head,
    input  cms_pkg::q_status_t  q_status,
    output logic                pop,
    output logic                result_valid,
    input  logic                result_stall,
    output logic [7:0]          out_byte,
    output logic                out_valid,
    output logic                last_of_run,
    output logic                item_dropped,
    output logic [15:0]         total_written
);
    import cms_pkg::*;
    `include "assert_macros.svh"

    logic              rv_reg;
    logic [BEAT_W-1:0] idx_reg, idx_next;
    logic [15:0]       cnt_reg, cnt_next;
    logic [7:0]        byte_reg;
    logic              valid_reg, last_reg, drop_reg;

    logic              load, have, beat_last;
    logic [15:0]       cur;

    assign have      = !q_status.empty;
    assign load      = !rv_reg || !result_stall;
    assign beat_last = (idx_reg == head.nbeats - 1'b1);
    assign pop       = load && have && beat_last;

    always_comb
    begin
        cur      = (idx_reg == '0) ? head.base : cnt_reg;
        cnt_next = (head.emit && cur != COUNT_MAX) ? cur + 16'd1 : cur;
        idx_next = beat_last ? '0 : idx_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg  <= 1'b0;
            idx_reg <= '0;
            cnt_reg <= '0;
        end
        else if (load)
        begin
            rv_reg <= have;
            if (have)
            begin
                idx_reg <= idx_next;
                cnt_reg <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && have)
        begin
            byte_reg  <= head.emit ? head.bytes[idx_reg] : 8'd0;
            valid_reg <= head.emit;
            last_reg  <= beat_last;
            drop_reg  <= head.dropped;
        end
    end

    assign result_valid  = rv_reg;
    assign out_byte      = byte_reg;
    assign out_valid     = valid_reg;
    assign last_of_run   = last_reg;
    assign item_dropped  = drop_reg;
    assign total_written = cnt_reg;

    `ASSERT_IMPLIES(a_idx_in_range, clk, rst_n, have, idx_reg < head.nbeats)
    `ASSERT_IMPLIES(a_idle_byte_zero, clk, rst_n, rv_reg && !valid_reg, byte_reg == 8'd0)
    `ASSERT_IMPLIES(a_multi_only_emit, clk, rst_n, rv_reg && !last_reg, valid_reg && !drop_reg)

endmodule
